// File: rtl/core/drq_pkg.sv
// Shared package for the two-priority draw request queue.
// Holds sizes, command and action codes, the queue entry type and the
// control structs that pass between the queue store and the sequencer.
package drq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ROOM_W      = 20;
    localparam int ROOM_H      = 20;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] CMD_ENQ_NORMAL = 3'd0;
    localparam logic [2:0] CMD_ENQ_HIGH   = 3'd1;
    localparam logic [2:0] CMD_NOTIFY     = 3'd2;
    localparam logic [2:0] CMD_DRAIN      = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;

    localparam logic [1:0] ACT_BLANK   = 2'd0;
    localparam logic [1:0] ACT_REDRAW  = 2'd1;
    localparam logic [1:0] ACT_BAD_WAY = 2'd2;

    localparam logic [2:0] WAY_BLACKED    = 3'd0;
    localparam logic [2:0] WAY_EVERYTHING = 3'd3;

    typedef struct packed {
        logic [7:0] room;
        logic [6:0] x;
        logic [6:0] y;
        logic [2:0] way;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic   valid;
        logic   high;
        entry_t entry;
    } push_req_t;

    typedef struct packed {
        logic valid;
        logic high;
    } pop_req_t;

    typedef struct packed {
        logic high_empty;
        logic normal_empty;
        logic overflow;
    } q_status_t;

endpackage

// File: rtl/core/drq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for both request queues.
module drq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/drq_queues.sv
// High and normal priority request queues: pointers, counts, overflow flag
// and two RAM instances. Depends on drq_pkg and drq_ram.
module drq_queues import drq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      clear,
    input  push_req_t push,
    input  pop_req_t  pop,
    output entry_t    rd_entry,
    output q_status_t status
);

    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0] high_rd_reg, high_rd_next;
    logic [PTR_W-1:0] high_wr_reg, high_wr_next;
    logic [CNT_W-1:0] high_cnt_reg, high_cnt_next;
    logic [PTR_W-1:0] normal_rd_reg, normal_rd_next;
    logic [PTR_W-1:0] normal_wr_reg, normal_wr_next;
    logic [CNT_W-1:0] normal_cnt_reg, normal_cnt_next;
    logic             overflow_reg, overflow_next;
    logic             rd_high_reg, rd_high_next;

    logic             high_we, normal_we, high_re, normal_re;
    logic             high_full, normal_full;
    logic [ENTRY_W-1:0] high_rdata, normal_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign high_full   = (high_cnt_reg == FULL_CNT);
    assign normal_full = (normal_cnt_reg == FULL_CNT);
    assign high_we     = push.valid && push.high && !high_full;
    assign normal_we   = push.valid && !push.high && !normal_full;
    assign high_re     = pop.valid && pop.high;
    assign normal_re   = pop.valid && !pop.high;

    always_comb
    begin
        high_rd_next    = high_rd_reg;
        high_wr_next    = high_wr_reg;
        high_cnt_next   = high_cnt_reg;
        normal_rd_next  = normal_rd_reg;
        normal_wr_next  = normal_wr_reg;
        normal_cnt_next = normal_cnt_reg;
        overflow_next   = overflow_reg;
        rd_high_next    = pop.valid ? pop.high : rd_high_reg;
        if (clear)
        begin
            high_rd_next    = '0;
            high_wr_next    = '0;
            high_cnt_next   = '0;
            normal_rd_next  = '0;
            normal_wr_next  = '0;
            normal_cnt_next = '0;
            overflow_next   = 1'b0;
        end
        else
        begin
            // A request to a full queue is dropped and remembered.
            if (push.valid && ((push.high && high_full) || (!push.high && normal_full)))
            begin
                overflow_next = 1'b1;
            end
            if (high_we)
            begin
                high_wr_next  = ptr_inc(high_wr_reg);
                high_cnt_next = CNT_W'(high_cnt_reg + 1'b1);
            end
            if (normal_we)
            begin
                normal_wr_next  = ptr_inc(normal_wr_reg);
                normal_cnt_next = CNT_W'(normal_cnt_reg + 1'b1);
            end
            if (high_re)
            begin
                high_rd_next  = ptr_inc(high_rd_reg);
                high_cnt_next = CNT_W'(high_cnt_reg - 1'b1);
            end
            if (normal_re)
            begin
                normal_rd_next  = ptr_inc(normal_rd_reg);
                normal_cnt_next = CNT_W'(normal_cnt_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_rd_reg    <= '0;
            high_wr_reg    <= '0;
            high_cnt_reg   <= '0;
            normal_rd_reg  <= '0;
            normal_wr_reg  <= '0;
            normal_cnt_reg <= '0;
            overflow_reg   <= 1'b0;
            rd_high_reg    <= 1'b0;
        end
        else
        begin
            high_rd_reg    <= high_rd_next;
            high_wr_reg    <= high_wr_next;
            high_cnt_reg   <= high_cnt_next;
            normal_rd_reg  <= normal_rd_next;
            normal_wr_reg  <= normal_wr_next;
            normal_cnt_reg <= normal_cnt_next;
            overflow_reg   <= overflow_next;
            rd_high_reg    <= rd_high_next;
        end
    end

    drq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_high_ram (
        .clk   (clk),
        .we    (high_we),
        .waddr (high_wr_reg),
        .wdata (push.entry),
        .re    (high_re),
        .raddr (high_rd_reg),
        .rdata (high_rdata)
    );

    drq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_normal_ram (
        .clk   (clk),
        .we    (normal_we),
        .waddr (normal_wr_reg),
        .wdata (push.entry),
        .re    (normal_re),
        .raddr (normal_rd_reg),
        .rdata (normal_rdata)
    );

    assign rd_entry            = entry_t'(rd_high_reg ? high_rdata : normal_rdata);
    assign status.high_empty   = (high_cnt_reg == '0);
    assign status.normal_empty = (normal_cnt_reg == '0);
    assign status.overflow     = overflow_reg;

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop.valid |-> (pop.high ? !status.high_empty : !status.normal_empty))
        else $error("pop from an empty queue");

    a_high_never_skipped: assert property (@(posedge clk) disable iff (!rst_n)
        (pop.valid && !pop.high) |-> status.high_empty)
        else $error("normal queue popped while high queue holds entries");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (high_cnt_reg <= FULL_CNT) && (normal_cnt_reg <= FULL_CNT))
        else $error("queue count beyond depth");

endmodule

// File: rtl/core/two_priority_draw_request_queue_core.sv
// Top level of the two-priority draw request queue: command decode, credit
// counter, drain sequencer and result register. Depends on drq_pkg and
// drq_queues.
//
//  Channel  Handshake            Payload
//  -------  -------------------  ------------------------------------------
//  request  req_valid/req_stall  cmd, room, x, y, way, budget, drain_all
//  result   res_valid/res_stall  out_room, out_x, out_y, action, overflow,
//                                last
//  config   cfg_wr_en            cfg_wr_data (room shown)
//
// Enqueue, notify, clear, unused commands and a drain whose budget less credits
// is zero (without drain_all) are done in their accept cycle; the sequencer stays idle.
// Any other drain is accepted, then pops each entry by a queue RAM read (CHECK)
// and a room compare (EVAL), then hands over its final item (FINAL).
// A drain that runs both queues empty also ends with an empty check (CHECK).
// Result stalls hold the sequencer only when it has an item to hand over.
// Reset is asynchronous; both queues come up empty with no clearing pass.
module two_priority_draw_request_queue_core import drq_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [2:0]        cmd,
    input  logic [7:0]        room,
    input  logic signed [7:0] x,
    input  logic signed [7:0] y,
    input  logic [2:0]        way,
    input  logic [6:0]        budget,
    input  logic              drain_all,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [7:0]        out_room,
    output logic [6:0]        out_x,
    output logic [6:0]        out_y,
    output logic [1:0]        action,
    output logic              overflow,
    output logic              last
);

    localparam logic [6:0] ROOM_W_LIM = 7'(ROOM_W);
    localparam logic [6:0] ROOM_H_LIM = 7'(ROOM_H);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EVAL,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic [7:0] room;
        logic [6:0] x;
        logic [6:0] y;
        logic [1:0] action;
    } res_item_t;

    state_t     state_reg, state_next;
    logic [7:0] view_room_reg, view_room_next;
    logic [7:0] credit_reg, credit_next;
    logic [6:0] want_reg, want_next;
    logic       all_reg, all_next;
    logic [6:0] kept_reg, kept_next;
    logic       pend_valid_reg, pend_valid_next;
    res_item_t  pend_reg, pend_next;
    logic       res_valid_reg, res_valid_next;
    res_item_t  res_item_reg, res_item_next;
    logic       res_last_reg, res_last_next;
    logic       res_overflow_reg, res_overflow_next;

    logic       accept;
    logic       slot_free;
    logic       both_empty;
    logic       room_match;
    logic       load_res;
    logic       load_last;
    logic [6:0] kept_inc;
    logic [7:0] credit_used;
    res_item_t  new_item;
    push_req_t  push;
    pop_req_t   pop;
    logic       clear;
    entry_t     rd_entry;
    q_status_t  status;

    function automatic logic coord_ok(input logic [7:0] v, input logic [6:0] limit);
        return !v[7] && (v[6:0] < limit);
    endfunction

    function automatic logic [1:0] way_action(input logic [2:0] w);
        logic [1:0] a;
        if (w == WAY_BLACKED)
            a = ACT_BLANK;
        else if (w <= WAY_EVERYTHING)
            a = ACT_REDRAW;
        else
            a = ACT_BAD_WAY;
        return a;
    endfunction

    assign req_stall  = (state_reg != ST_IDLE);
    assign accept     = req_valid && !req_stall;
    assign slot_free  = !res_valid_reg || !res_stall;
    assign both_empty = status.high_empty && status.normal_empty;
    assign room_match = (rd_entry.room == view_room_reg);
    assign kept_inc   = 7'(kept_reg + 7'd1);
    assign credit_used = (credit_reg > {1'b0, budget}) ? {1'b0, budget} : credit_reg;

    assign new_item.room   = rd_entry.room;
    assign new_item.x      = rd_entry.x;
    assign new_item.y      = rd_entry.y;
    assign new_item.action = way_action(rd_entry.way);

    assign push.valid       = accept && ((cmd == CMD_ENQ_NORMAL) || (cmd == CMD_ENQ_HIGH))
                              && coord_ok(x, ROOM_W_LIM) && coord_ok(y, ROOM_H_LIM);
    assign push.high        = (cmd == CMD_ENQ_HIGH);
    assign push.entry.room  = room;
    assign push.entry.x     = x[6:0];
    assign push.entry.y     = y[6:0];
    assign push.entry.way   = way;
    assign clear            = accept && (cmd == CMD_CLEAR);
    assign pop.valid        = (state_reg == ST_CHECK) && !both_empty;
    assign pop.high         = !status.high_empty;

    drq_queues u_queues (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (clear),
        .push     (push),
        .pop      (pop),
        .rd_entry (rd_entry),
        .status   (status)
    );

    // Each kept entry waits in the pending register until the next kept
    // entry or the end of the run shows whether it is the final item.
    always_comb
    begin
        state_next        = state_reg;
        view_room_next    = cfg_wr_en ? cfg_wr_data : view_room_reg;
        credit_next       = credit_reg;
        want_next         = want_reg;
        all_next          = all_reg;
        kept_next         = kept_reg;
        pend_valid_next   = pend_valid_reg;
        pend_next         = pend_reg;
        load_res          = 1'b0;
        load_last         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd == CMD_NOTIFY)
                    begin
                        if (credit_reg != 8'hFF)
                            credit_next = 8'(credit_reg + 8'd1);
                    end
                    else if (cmd == CMD_CLEAR)
                    begin
                        credit_next = '0;
                    end
                    else if (cmd == CMD_DRAIN)
                    begin
                        credit_next     = '0;
                        all_next        = drain_all;
                        want_next       = 7'(budget - credit_used[6:0]);
                        kept_next       = '0;
                        pend_valid_next = 1'b0;
                        if (drain_all || (7'(budget - credit_used[6:0]) != '0))
                            state_next = ST_CHECK;
                    end
                    else
                    begin
                        credit_next = credit_reg;
                    end
                end
            end
            ST_CHECK:
            begin
                if (both_empty)
                    state_next = pend_valid_reg ? ST_FINAL : ST_IDLE;
                else
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // Entries for another room are dropped without counting.
                if (!room_match)
                begin
                    state_next = ST_CHECK;
                end
                else if (!pend_valid_reg || slot_free)
                begin
                    load_res        = pend_valid_reg;
                    pend_next       = new_item;
                    pend_valid_next = 1'b1;
                    kept_next       = kept_inc;
                    if (!all_reg && (kept_inc == want_reg))
                        state_next = ST_FINAL;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_FINAL:
            begin
                if (slot_free)
                begin
                    load_res        = 1'b1;
                    load_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_res)
        begin
            res_valid_next    = 1'b1;
            res_item_next     = pend_reg;
            res_last_next     = load_last;
            res_overflow_next = status.overflow;
        end
        else
        begin
            res_valid_next    = res_valid_reg && res_stall;
            res_item_next     = res_item_reg;
            res_last_next     = res_last_reg;
            res_overflow_next = res_overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            view_room_reg    <= '0;
            credit_reg       <= '0;
            want_reg         <= '0;
            all_reg          <= 1'b0;
            kept_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            pend_reg         <= '0;
            res_valid_reg    <= 1'b0;
            res_item_reg     <= '0;
            res_last_reg     <= 1'b0;
            res_overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            view_room_reg    <= view_room_next;
            credit_reg       <= credit_next;
            want_reg         <= want_next;
            all_reg          <= all_next;
            kept_reg         <= kept_next;
            pend_valid_reg   <= pend_valid_next;
            pend_reg         <= pend_next;
            res_valid_reg    <= res_valid_next;
            res_item_reg     <= res_item_next;
            res_last_reg     <= res_last_next;
            res_overflow_reg <= res_overflow_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign out_room  = res_item_reg.room;
    assign out_x     = res_item_reg.x;
    assign out_y     = res_item_reg.y;
    assign action    = res_item_reg.action;
    assign overflow  = res_overflow_reg;
    assign last      = res_last_reg;

    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (load_res && load_last) |=> (state_reg == ST_IDLE))
        else $error("drain still running after its final item");

    a_pending_counted: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (kept_reg != '0))
        else $error("pending item without a kept count");

    a_kept_within_want: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_IDLE) && !all_reg) |-> (kept_reg <= want_reg))
        else $error("drain kept more entries than its budget");

    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |->
            (($past(state_reg) == ST_CHECK) || ($past(state_reg) == ST_EVAL)))
        else $error("entry evaluated without a queue read");

endmodule
